[rtl/csi_pkg.sv]
package csi_pkg;

	localparam int MaxSubcarriersDef = 256;
	localparam int CordicStagesDef   = 16;

	localparam logic [7:0]  MAGIC_BYTE   = 8'h11;
	localparam int          HdrLen       = 18;
	localparam logic [17:0] MAG_MAX      = 18'd185364;
	localparam int          PhaseMax     = 25736;
	localparam int          HalfPiQ16    = 102944;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SUB    = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] FID_RSSI    = 3'd0;
	localparam logic [2:0] FID_ADDR    = 3'd1;
	localparam logic [2:0] FID_SEQ     = 3'd2;
	localparam logic [2:0] FID_STREAM  = 3'd3;
	localparam logic [2:0] FID_CHANNEL = 3'd4;
	localparam logic [2:0] FID_CHIP    = 3'd5;

	localparam logic [1:0] REG_NATIVE  = 2'd0;
	localparam logic [1:0] REG_DISPLAY = 2'd1;
	localparam logic [1:0] REG_EXPORT  = 2'd2;
	localparam logic [1:0] REG_RSSI    = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} csi_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  field_id;
		logic [47:0] field_value;
		logic [7:0]  sub_index;
		logic [17:0] magnitude;
		logic [15:0] phase;
		logic        to_display;
		logic        to_export;
		logic        last;
	} csi_out_t;

	// command from controller to cordic datapath
	typedef struct packed {
		logic        start;
		logic [15:0] re;
		logic [15:0] im;
	} csi_cmd_t;

	typedef struct packed {
		logic        done;
		logic [17:0] magnitude;
		logic [15:0] phase;
	} csi_sts_t;

	function automatic logic [16:0] atan_q16(input logic [4:0] i);
		case (i)
			5'd0: atan_q16 = 17'd51472;
			5'd1: atan_q16 = 17'd30385;
			5'd2: atan_q16 = 17'd16055;
			5'd3: atan_q16 = 17'd8150;
			5'd4: atan_q16 = 17'd4091;
			5'd5: atan_q16 = 17'd2047;
			5'd6: atan_q16 = 17'd1024;
			5'd7: atan_q16 = 17'd512;
			5'd8: atan_q16 = 17'd256;
			5'd9: atan_q16 = 17'd128;
			5'd10: atan_q16 = 17'd64;
			5'd11: atan_q16 = 17'd32;
			5'd12: atan_q16 = 17'd16;
			5'd13: atan_q16 = 17'd8;
			5'd14: atan_q16 = 17'd4;
			5'd15: atan_q16 = 17'd2;
			5'd16: atan_q16 = 17'd1;
			default: atan_q16 = 17'd0;
		endcase
	endfunction

endpackage

[rtl/csi_frame_polar_extractor.sv]
// channel   dir  handshake          request
// in        in   in_valid/in_stall  data_byte, frame_start
// out       out  out_valid/out_stall kind..last result
// cfg       in   cfg_valid/cfg_ready index + data
// a header or pair byte is taken as it comes; the last byte of a windowed subcarrier
// stalls input while the shared cordic unit works on the pair (a zero pair skips the
// iterations), longer while an earlier result still waits in the output register
// one output register; input stalls while it is full and stalled
// reset clears position and frame state and sets the configuration registers to their defaults
module csi_frame_polar_extractor import csi_pkg::*; #(
	parameter int MAX_SUBCARRIERS = MaxSubcarriersDef,
	parameter int CORDIC_STAGES   = CordicStagesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  csi_in_t    in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output csi_out_t   out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_data
);
	csi_cmd_t cmd;
	csi_sts_t sts;

	// byte parser and result sequencing
	csi_ctrl #(.MAX_SUBCARRIERS(MAX_SUBCARRIERS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.cmd, .sts
	);

	// iterative vectoring cordic
	csi_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk, .arst_n, .cmd, .sts
	);
endmodule

[rtl/csi_cordic.sv]
module csi_cordic import csi_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStagesDef
) (
	input  logic     clk,
	input  logic     arst_n,
	input  csi_cmd_t cmd,
	output csi_sts_t sts
);
	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_ITER = 3'b010,
		C_FIN  = 3'b100
	} cst_t;

	cst_t state_q;
	logic [4:0] iter_q;
	logic signed [26:0] x_q, y_q;
	logic signed [19:0] z_q;
	logic [17:0] mag_q;
	logic [15:0] ph_q;
	logic done_q;

	logic signed [26:0] x0, y0, xs, ys;
	logic signed [19:0] z0, zr;
	logic signed [16:0] ps;
	logic [56:0] prod;
	logic [20:0] mr;

	always_comb begin
		x0 = 27'(signed'(cmd.re)) <<< 8;
		y0 = 27'(signed'(cmd.im)) <<< 8;
		z0 = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				x0 = y0; y0 = -(27'(signed'(cmd.re)) <<< 8); z0 = 20'(HalfPiQ16);
			end else begin
				x0 = -y0; y0 = 27'(signed'(cmd.re)) <<< 8; z0 = -20'(HalfPiQ16);
			end
		end
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		prod = 57'(x_q[26] ? 27'd0 : x_q) * 57'(INV_GAIN_Q30) + (57'd1 << 35);
		mr = prod[56:36];
		zr = (z_q + 20'sd4) >>> 3;
		if (zr > 20'(PhaseMax)) ps = 17'(PhaseMax);
		else if (zr < -20'(PhaseMax)) ps = -17'(PhaseMax);
		else ps = zr[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (cmd.start) begin
						x_q <= x0; y_q <= y0; z_q <= z0; iter_q <= '0;
						if (cmd.re == 16'd0 && cmd.im == 16'd0) begin
							mag_q <= '0; ph_q <= '0; done_q <= 1'b1;
						end else
							state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (y_q >= 0) begin
						x_q <= x_q + ys; y_q <= y_q - xs;
						z_q <= z_q + 20'(atan_q16(iter_q));
					end else begin
						x_q <= x_q - ys; y_q <= y_q + xs;
						z_q <= z_q - 20'(atan_q16(iter_q));
					end
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(CORDIC_STAGES - 1)) state_q <= C_FIN;
				end
				C_FIN: begin
					mag_q <= (mr > 21'(MAG_MAX)) ? MAG_MAX : mr[17:0];
					ph_q <= 16'(ps);
					done_q <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign sts.done = done_q;
	assign sts.magnitude = mag_q;
	assign sts.phase = ph_q;
endmodule

[rtl/csi_ctrl.sv]
module csi_ctrl import csi_pkg::*; #(
	parameter int MAX_SUBCARRIERS = MaxSubcarriersDef
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  csi_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output csi_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_data,
	output csi_cmd_t cmd,
	input  csi_sts_t sts
);
	typedef enum logic [2:0] {
		S_PARSE = 3'b001,
		S_WAIT  = 3'b010,
		S_LOAD  = 3'b100
	} st_t;

	st_t state_q;
	logic [1:0] nat_q, disp_q, exp_q;
	logic rssi_q;
	logic [10:0] pos_q;
	logic good_q;
	logic [47:0] hdr_q;
	logic [23:0] pair_q;
	csi_out_t res_q, pend_q;
	logic ovalid_q;

	logic [8:0] ncount;
	logic [10:0] total;
	logic [7:0] dlo, dhi, elo, ehi, lo, hi, idx;
	logic [10:0] off, pcur;
	logic good, fire, take;
	logic [47:0] hnext;
	csi_out_t r, res_d;
	logic emit, to_cordic;
	logic out_free, load_sub, load_res;

	function automatic logic [15:0] win(input logic [8:0] n, input logic [1:0] s);
		logic [7:0] l, h;
		if (n >= 9'd256) begin
			l = (s <= 2'd1) ? 8'd128 : 8'd0;
			h = (s == 2'd0) ? 8'd191 : 8'd255;
		end else if (n >= 9'd128) begin
			l = (s == 2'd0) ? 8'd64 : 8'd0;
			h = 8'd127;
		end else begin
			l = 8'd0; h = 8'd63;
		end
		return {l, h};
	endfunction

	always_comb begin
		ncount = (nat_q == 2'd0) ? 9'd64 : (nat_q == 2'd1) ? 9'd128 : 9'd256;
		if (ncount > 9'(MAX_SUBCARRIERS) && ncount > 9'd64) ncount = ncount >> 1;
		if (ncount > 9'(MAX_SUBCARRIERS) && ncount > 9'd64) ncount = ncount >> 1;
		total = 11'(HdrLen) + {ncount, 2'b00};
		{dlo, dhi} = win(ncount, disp_q);
		{elo, ehi} = win(ncount, exp_q);
		lo = (dlo < elo) ? dlo : elo;
		hi = (dhi > ehi) ? dhi : ehi;
		off = pos_q - 11'(HdrLen);
		idx = off[9:2];
		pcur = in_data.frame_start ? 11'd0 : pos_q;
		// slot free when nothing is waiting or it leaves now
		out_free = !ovalid_q || !out_stall;
		take = in_valid && !in_stall;
		good = in_data.frame_start || good_q;
		hnext = {hdr_q[39:0], in_data.data_byte};
		r = '0;
		emit = 1'b0;
		to_cordic = 1'b0;
		fire = take && good && !(in_data.frame_start ? 1'b0 : pos_q >= total);
		if (fire) begin
			if (pcur < 11'(HdrLen)) begin
				case (pcur)
					11'd3: begin
						emit = 1'b1; r.field_id = FID_RSSI;
						r.field_value = rssi_q ? {32'd0, hnext[15:0]} : 48'd0;
					end
					11'd9: begin emit = 1'b1; r.field_id = FID_ADDR; r.field_value = hnext; end
					11'd11: begin
						emit = 1'b1; r.field_id = FID_SEQ; r.field_value = {32'd0, hnext[15:0]};
					end
					11'd13, 11'd15, 11'd17: begin
						emit = 1'b1;
						r.field_id = (pos_q == 11'd13) ? FID_STREAM :
							(pos_q == 11'd15) ? FID_CHANNEL : FID_CHIP;
						r.field_value = {32'd0, hnext[7:0], hnext[15:8]};
					end
					default: ;
				endcase
				r.kind = KIND_HEADER;
				if ((pcur < 11'd2 || (!rssi_q && pos_q < 11'd4)) &&
					in_data.data_byte != MAGIC_BYTE) begin
					r = '0; r.kind = KIND_ERROR; r.last = 1'b1; emit = 1'b1;
				end
			end else if (off[1:0] == 2'd3 && idx >= lo && idx <= hi) begin
				to_cordic = 1'b1;
				r.kind = KIND_SUB;
				r.sub_index = idx;
				r.to_display = (idx >= dlo && idx <= dhi);
				r.to_export = (idx >= elo && idx <= ehi);
				r.last = (idx == hi);
			end
		end
		// polar result moves to the output register once it is free
		load_sub = ((state_q == S_WAIT && sts.done) || state_q == S_LOAD) && out_free;
		load_res = (fire && emit) || load_sub;
		res_d = r;
		if (load_sub) begin
			res_d = pend_q;
			res_d.magnitude = sts.magnitude;
			res_d.phase = sts.phase;
		end
	end

	assign in_stall = (state_q != S_PARSE) || (ovalid_q && out_stall);
	assign cfg_ready = 1'b1;
	assign cmd.start = to_cordic;
	assign cmd.re = pair_q[15:0];
	assign cmd.im = {in_data.data_byte, pair_q[23:16]};
	assign out_valid = ovalid_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_PARSE;
			nat_q <= '0; disp_q <= '0; exp_q <= '0; rssi_q <= 1'b1;
			pos_q <= '0; good_q <= 1'b0; hdr_q <= '0; pair_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_NATIVE:  nat_q <= cfg_data;
					REG_DISPLAY: disp_q <= cfg_data;
					REG_EXPORT:  exp_q <= cfg_data;
					REG_RSSI:    rssi_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (load_res) begin
				res_q <= res_d; ovalid_q <= 1'b1;
			end else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (take && good) begin
				if (!fire) good_q <= 1'b0;
				else begin
					pos_q <= pcur + 11'd1;
					good_q <= (pcur + 11'd1 < total) && !(emit && r.kind == KIND_ERROR);
					if (pcur < 11'(HdrLen)) hdr_q <= hnext;
					else case (off[1:0])
						2'd0: pair_q <= {16'd0, in_data.data_byte};
						2'd1: pair_q[15:8] <= in_data.data_byte;
						2'd2: pair_q[23:16] <= in_data.data_byte;
						default: ;
					endcase
					if (to_cordic) begin
						pend_q <= r; state_q <= S_WAIT;
					end
				end
			end
			if (load_sub) state_q <= S_PARSE;
			else if (state_q == S_WAIT && sts.done) state_q <= S_LOAD;
		end
	end
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import csi_pkg::*;

	// polar results, header fields and errors expected from the parser, oldest first
	class csi_scoreboard;
		csi_out_t pending_results[$];
		int       mismatch_count;

		// configuration copy
		logic [1:0] native_sel, display_sel, export_sel;
		logic       rssi_on;

		// parser state
		int          byte_pos;
		bit          in_frame;
		logic [47:0] header_bits;
		logic [23:0] pair_bits;

		function void reset_state();
			native_sel = 0; display_sel = 0; export_sel = 0; rssi_on = 1;
			byte_pos = 0; in_frame = 0; header_bits = 0; pair_bits = 0;
			pending_results.delete();
			mismatch_count = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [1:0] val);
			case (idx)
				REG_NATIVE: native_sel = val;
				REG_DISPLAY: display_sel = val;
				REG_EXPORT: export_sel = val;
				REG_RSSI: rssi_on = val[0];
				default: ;
			endcase
		endfunction

		function int captured_count();
			int n;
			n = native_sel == 0 ? 64 : native_sel == 1 ? 128 : 256;
			while (n > MaxSubcarriersDef && n > 64) n = n >> 1;
			return n;
		endfunction

		function void window_bounds(int n, logic [1:0] sel, output int lo, output int hi);
			if (n >= 256) begin
				lo = sel <= 1 ? 128 : 0;
				hi = sel == 0 ? 191 : 255;
			end else if (n >= 128) begin
				lo = sel == 0 ? 64 : 0;
				hi = 127;
			end else begin
				lo = 0;
				hi = 63;
			end
		endfunction

		// arithmetic shift right rounding toward minus infinity
		function longint shr_floor(longint v, int s);
			return v >>> s;
		endfunction

		function void cordic_polar(int re, int im, output logic [17:0] mag,
				output logic [15:0] ph);
			longint x, y, z, t, xs, ys, p;
			longint unsigned ux, m;
			longint angles [20];
			angles = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
				64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
			x = longint'(re) * 256;
			y = longint'(im) * 256;
			z = 0;
			if (re == 0 && im == 0) begin
				mag = 0;
				ph = 0;
				return;
			end
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = HalfPiQ16;
				end else begin
					t = x; x = -y; y = t; z = -HalfPiQ16;
				end
			end
			for (int i = 0; i < CordicStagesDef && i < 20; i++) begin
				xs = shr_floor(x, i);
				ys = shr_floor(y, i);
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + angles[i];
				end else begin
					x = x - ys; y = y + xs; z = z - angles[i];
				end
			end
			ux = x > 0 ? x : 0;
			m = (ux * 64'd652032875 + (64'd1 << 35)) >> 36;
			if (m > MAG_MAX) m = MAG_MAX;
			mag = m[17:0];
			p = shr_floor(z + 4, 3);
			if (p > PhaseMax) p = PhaseMax;
			if (p < -PhaseMax) p = -PhaseMax;
			ph = p[15:0];
		endfunction

		// note one accepted byte and queue the result it causes, if any
		function void note_byte(csi_in_t req);
			csi_out_t r;
			int n, total, p, off, idx, dlo, dhi, elo, ehi, lo, hi, re, im;
			logic [7:0] b;
			b = req.data_byte;
			n = captured_count();
			total = HdrLen + 4 * n;
			r = '0;
			if (req.frame_start) begin
				byte_pos = 0;
				in_frame = 1;
			end
			if (!in_frame) return;
			p = byte_pos;
			if (p >= total) begin
				in_frame = 0;
				return;
			end
			byte_pos = (p + 1) & 11'h7ff;
			if (p + 1 >= total) in_frame = 0;
			if (p < HdrLen) begin
				header_bits = {header_bits[39:0], b};
				if (p < 2 || (!rssi_on && p < 4)) begin
					if (b != MAGIC_BYTE) begin
						in_frame = 0;
						r.kind = KIND_ERROR;
						r.last = 1;
						pending_results.push_back(r);
						return;
					end
				end
				r.kind = KIND_HEADER;
				case (p)
					3: begin
						r.field_id = FID_RSSI;
						r.field_value = rssi_on ? {32'd0, header_bits[15:0]} : '0;
					end
					9: begin
						r.field_id = FID_ADDR;
						r.field_value = header_bits;
					end
					11: begin
						r.field_id = FID_SEQ;
						r.field_value = {32'd0, header_bits[15:0]};
					end
					13, 15, 17: begin
						r.field_id = p == 13 ? FID_STREAM : p == 15 ? FID_CHANNEL : FID_CHIP;
						r.field_value = {32'd0, header_bits[7:0], header_bits[15:8]};
					end
					default: return;
				endcase
				pending_results.push_back(r);
				return;
			end
			off = p - HdrLen;
			idx = off >> 2;
			case (off & 3)
				0: begin
					pair_bits = {16'd0, b};
					return;
				end
				1: begin
					pair_bits[15:8] = b;
					return;
				end
				2: begin
					pair_bits[23:16] = b;
					return;
				end
				default: ;
			endcase
			window_bounds(n, display_sel, dlo, dhi);
			window_bounds(n, export_sel, elo, ehi);
			lo = dlo < elo ? dlo : elo;
			hi = dhi > ehi ? dhi : ehi;
			if (idx < lo || idx > hi) return;
			re = int'($signed(pair_bits[15:0]));
			im = int'($signed({b, pair_bits[23:16]}));
			r.kind = KIND_SUB;
			r.sub_index = idx[7:0];
			cordic_polar(re, im, r.magnitude, r.phase);
			r.to_display = idx >= dlo && idx <= dhi;
			r.to_export = idx >= elo && idx <= ehi;
			r.last = idx == hi;
			pending_results.push_back(r);
		endfunction

		function void check_result(csi_out_t got);
			csi_out_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				mismatch_count++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (got !== exp_r) begin
				$display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
				if (got.kind !== exp_r.kind)
					$display("  kind expected %0d actual %0d", exp_r.kind, got.kind);
				if (got.field_value !== exp_r.field_value)
					$display("  field_value expected %h actual %h",
						exp_r.field_value, got.field_value);
				if (got.magnitude !== exp_r.magnitude || got.phase !== exp_r.phase)
					$display("  idx %0d mag/phase expected %0d/%0d actual %0d/%0d",
						exp_r.sub_index, exp_r.magnitude, $signed(exp_r.phase),
						got.magnitude, $signed(got.phase));
				mismatch_count++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	csi_in_t    in_data;
	logic       out_valid;
	logic       out_stall;
	csi_out_t   out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [1:0] cfg_data;

	csi_scoreboard frame_sb;
	int  cycle_count;
	int  idle_pct;         // idling percent for both sides
	bit  hold_receiver;    // long receiver hold-off request
	int  bytes_sent;

	csi_frame_polar_extractor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// global watchdog on cycles
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stall, checks every accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) frame_sb.check_result(out_data);
			if (hold_receiver) out_stall <= 1'b1;
			else out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// send one byte, with random idle cycles before it
	task automatic send_byte(logic [7:0] b, logic fs);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, frame_start: fs};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		frame_sb.note_byte(in_data);
		bytes_sent++;
	endtask

	// wait until no expected result is pending, then wait further for the cordic to settle
	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (frame_sb.pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (CordicStagesDef + 20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		frame_sb.write_reg(idx, val);
	endtask

	task automatic set_config(logic [1:0] nat, logic [1:0] disp, logic [1:0] expo, logic rs);
		drain();
		write_cfg(REG_NATIVE, nat);
		write_cfg(REG_DISPLAY, disp);
		write_cfg(REG_EXPORT, expo);
		write_cfg(REG_RSSI, {1'b0, rs});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_sample_byte(int k);
		// bias some pairs toward extremes and zero
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			2: return k[0] ? 8'h80 : 8'h00;
			3: return k[0] ? 8'h7f : 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// one frame; short_len cuts it, bad_magic corrupts a magic byte
	task automatic send_frame(int nsub, int short_len, bit bad_magic, int extra);
		int total;
		logic [7:0] b;
		total = HdrLen + 4 * nsub;
		if (short_len > 0 && short_len < total) total = short_len;
		for (int i = 0; i < total + extra; i++) begin
			if (i < 4) b = MAGIC_BYTE;
			else if (i < HdrLen) b = 8'($urandom_range(255));
			else b = rand_sample_byte(i);
			if (i < 4 && $urandom_range(3) == 0 && frame_sb.rssi_on == 0) b = MAGIC_BYTE;
			if (i < 4 && frame_sb.rssi_on && i >= 2) b = 8'($urandom_range(255));
			if (bad_magic && i == $urandom_range(frame_sb.rssi_on ? 1 : 3))
				b = 8'($urandom_range(255));
			send_byte(b, i == 0);
		end
	endtask

	initial begin
		int ncnt;
		logic [1:0] nat, disp, expo;
		frame_sb = new();
		frame_sb.reset_state();
		cycle_count = 0;
		idle_pct = 31;
		hold_receiver = 0;
		bytes_sent = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = REG_NATIVE;
		cfg_data = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray bytes before a frame, then magic errors and a short frame
		send_byte(8'h11, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h11, 1'b1);
		send_byte(8'h12, 1'b0);
		// rssi off: bad fourth magic byte
		set_config(2'd0, 2'd0, 2'd0, 1'b0);
		send_byte(8'h11, 1'b1);
		send_byte(8'h11, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h00, 1'b0);
		// restart mid-header, then extreme header bytes and pairs
		for (int i = 0; i < 6; i++) send_byte(MAGIC_BYTE, i == 0);
		for (int i = 0; i < 4; i++) send_byte(MAGIC_BYTE, i == 0);
		for (int i = 4; i < HdrLen; i++) send_byte(i[0] ? 8'hff : 8'h80, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);

		// full frames on the wider settings, selector three included
		for (int c = 0; c < 2; c++) begin
			nat = (c == 0) ? 2'd1 : 2'd3;
			disp = (c == 0) ? 2'd0 : 2'd1;
			expo = (c == 0) ? 2'd3 : 2'd0;
			set_config(nat, disp, expo, c == 1);
			ncnt = frame_sb.captured_count();
			// long stretch without idling on one phase
			idle_pct = (c == 1) ? 0 : 31;
			// receiver hold-off while bytes keep coming
			if (c == 0) begin
				fork
					begin
						hold_receiver = 1;
						repeat (300) @(posedge clk);
						hold_receiver = 0;
					end
				join_none
			end
			send_frame(ncnt, 0, 0, (c == 0) ? 3 : 0);
			if ($urandom_range(1) == 0) send_frame(ncnt, 10, 1, 0);
			if ($urandom_range(1) == 0) send_frame(ncnt, $urandom_range(60, 4), 0, 0);
		end
		idle_pct = 31;
		// random traffic on the smallest setting until the byte budget is met
		set_config(2'd0, 2'd0, 2'd0, 1'b1);
		while (bytes_sent < 1800) begin
			case ($urandom_range(9))
				0: send_frame(64, 12, 1, 0);
				1: send_frame(64, $urandom_range(100, 2), 0, 0);
				2: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
				default: send_frame(64, 0, 0, 0);
			endcase
		end

		drain();
		if (frame_sb.mismatch_count == 0 && frame_sb.pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/csi_pkg.sv
rtl/csi_cordic.sv
rtl/csi_ctrl.sv
rtl/csi_frame_polar_extractor.sv
sim/tb_top.sv
